[src/rotation_compose_normalize_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the rotation compose and normalize core.
// Each macro checks a property on the rising edge of i_clk, outside reset.
// ----------------------------------------------------------------------------
`ifndef ROTATION_COMPOSE_NORMALIZE_CORE_MACROS_SVH
`define ROTATION_COMPOSE_NORMALIZE_CORE_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define RCN_ASSERT_IMP(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (prop)) else $error("rcn check failed");

// The consequence must hold in the cycle after the condition.
`define RCN_ASSERT_NXT(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (prop)) else $error("rcn check failed");

`endif

[src/rcn_pkg.sv]
// ----------------------------------------------------------------------------
// rcn_pkg
// Shared widths, defaults and types of the rotation compose and normalize core.
// ----------------------------------------------------------------------------
package rcn_pkg;

    // Default number of fraction bits of the result format.
    localparam int FRAC_BITS_DEF = 14;

    // Magnitude of a normalized product part, and the sum of two squares.
    localparam int MAG_W = 32;
    localparam int RAD_W = 2 * MAG_W;

    // One result as it leaves the pipeline.
    typedef struct packed {
        logic        deg;
        logic [15:0] sin;
        logic [15:0] cos;
    } t_res;

endpackage

[src/rcn_sqrt_pipe.sv]
// ----------------------------------------------------------------------------
// rcn_sqrt_pipe
// Pipelined integer square root, an entry stage and then one result bit per stage, with sideband.
// ----------------------------------------------------------------------------
module rcn_sqrt_pipe #(
    parameter int SIDE_W = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  logic [rcn_pkg::RAD_W-1:0]  i_rad,
    input  logic [SIDE_W-1:0]          i_side,
    output logic                       o_vld,
    output logic [rcn_pkg::MAG_W-1:0]  o_root,
    output logic [SIDE_W-1:0]          o_side
);

    localparam int STEPS = rcn_pkg::RAD_W / 2;
    localparam int RT_W  = rcn_pkg::MAG_W;
    localparam int REM_W = RT_W + 3;

    logic                      r_vld  [0:STEPS];
    logic [rcn_pkg::RAD_W-1:0] r_rad  [0:STEPS];
    logic [REM_W-1:0]          r_rem  [0:STEPS];
    logic [RT_W-1:0]           r_root [0:STEPS];
    logic [SIDE_W-1:0]         r_side [0:STEPS];

    // Entry stage takes the radicand with a cleared remainder and root.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad[0]  <= i_rad;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_side[0] <= i_side;
        end
    end

    // Each stage brings in two radicand bits and decides one root bit.
    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [REM_W-1:0] w_acc;
        logic [REM_W-1:0] w_trial;
        logic             w_ge;

        assign w_acc   = {r_rem[k][REM_W-3:0], r_rad[k][rcn_pkg::RAD_W-1 -: 2]};
        assign w_trial = {1'b0, r_root[k], 2'b01};
        assign w_ge    = (w_acc >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= w_ge ? (w_acc - w_trial) : w_acc;
                r_root[k+1] <= {r_root[k][RT_W-2:0], w_ge};
                r_rad[k+1]  <= {r_rad[k][rcn_pkg::RAD_W-3:0], 2'b00};
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_vld  = r_vld[STEPS];
    assign o_root = r_root[STEPS];
    assign o_side = r_side[STEPS];

endmodule

[src/rcn_div_pipe.sv]
// ----------------------------------------------------------------------------
// rcn_div_pipe
// Pipelined rounded division of a scaled magnitude by the norm.
// ----------------------------------------------------------------------------
module rcn_div_pipe #(
    parameter int FRAC_BITS = rcn_pkg::FRAC_BITS_DEF,
    parameter int SIDE_W    = 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_vld,
    input  logic [rcn_pkg::MAG_W-1:0] i_mag,
    input  logic [rcn_pkg::MAG_W-1:0] i_norm,
    input  logic [SIDE_W-1:0]         i_side,
    output logic                      o_vld,
    output logic [FRAC_BITS:0]        o_quo,
    output logic [SIDE_W-1:0]         o_side
);

    localparam int STEPS = FRAC_BITS + 1;
    localparam int MW    = rcn_pkg::MAG_W;
    localparam int NUM_W = MW + STEPS;

    logic [NUM_W-1:0] w_num;

    logic              r_vld  [0:STEPS];
    logic [MW-1:0]     r_rem  [0:STEPS];
    logic [STEPS-1:0]  r_low  [0:STEPS];
    logic [STEPS-1:0]  r_quo  [0:STEPS];
    logic [MW-1:0]     r_norm [0:STEPS];
    logic [SIDE_W-1:0] r_side [0:STEPS];

    // Numerator with half the divisor added for round to nearest.
    assign w_num = NUM_W'({i_mag, {FRAC_BITS{1'b0}}}) + NUM_W'(i_norm >> 1);

    // The quotient fits in STEPS bits, so the top part starts below the norm.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= w_num[NUM_W-1 -: MW];
            r_low[0]  <= w_num[STEPS-1:0];
            r_quo[0]  <= '0;
            r_norm[0] <= i_norm;
            r_side[0] <= i_side;
        end
    end

    // One restoring step per stage.
    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [MW:0] w_t;
        logic [MW:0] w_d;
        logic        w_ge;

        assign w_t  = {r_rem[k], r_low[k][STEPS-1]};
        assign w_d  = w_t - {1'b0, r_norm[k]};
        assign w_ge = (w_t >= {1'b0, r_norm[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= w_ge ? w_d[MW-1:0] : w_t[MW-1:0];
                r_low[k+1]  <= r_low[k] << 1;
                r_quo[k+1]  <= {r_quo[k][STEPS-2:0], w_ge};
                r_norm[k+1] <= r_norm[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_vld  = r_vld[STEPS];
    assign o_quo  = r_quo[STEPS];
    assign o_side = r_side[STEPS];

endmodule

[src/rotation_compose_normalize_core.sv]
// ----------------------------------------------------------------------------
// rotation_compose_normalize_core
// Composes two rotations and scales the product back onto the unit circle.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one pair of rotations per transaction: tdata holds
// a_cos, a_sin, b_cos, b_sin (Q1.14 each) and tuser selects a plus b (0) or
// a minus b (1). The master channel returns one transaction per input with
// res_cos and res_sin in tdata and the degenerate flag in tuser.
// Throughput is one transaction per cycle while o_s_tready is high. The path
// from acceptance to the result on the master side runs through eight stages
// of multiply, normalize and square, 33 stages of the square root (an entry
// stage and one per root bit), FRAC_BITS + 2 stages of the two dividers, a
// saturation stage and the output register.
// Reset clears every valid bit, so the pipeline comes up empty.
// When the receiver stalls, the output register holds its result and one more
// result lands in a skid register; the pipeline then halts as a whole and
// o_s_tready drops until the skid register drains. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "rotation_compose_normalize_core_macros.svh"

module rotation_compose_normalize_core #(
    parameter int FRAC_BITS = rcn_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,  // a_cos[15:0], a_sin[31:16], b_cos[47:32], b_sin[63:48]
    input  logic        i_s_tuser,  // func[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,  // res_cos[15:0], res_sin[31:16]
    output logic        o_m_tuser   // degenerate[0]
);

    localparam int MW = rcn_pkg::MAG_W;
    localparam logic [31:0] ONE   = 32'(64'(1) << FRAC_BITS);
    localparam logic [31:0] LIM_P = (ONE < 32'd32767) ? ONE : 32'd32767;
    localparam logic [31:0] LIM_N = (ONE < 32'd32768) ? ONE : 32'd32768;

    // Count of leading zeros of a 16-bit field, 16 when it is all zero.
    function automatic logic [4:0] lz16(input logic [15:0] v);
        logic [4:0] n;
        logic       found;
        n     = '0;
        found = 1'b0;
        for (int i = 15; i >= 0; i--) begin
            if (!found) begin
                if (v[i]) begin
                    found = 1'b1;
                end else begin
                    n = n + 5'd1;
                end
            end
        end
        return n;
    endfunction

    // Global advance: the pipeline moves while the skid register is empty.
    logic w_en;
    logic r_skid_vld;
    assign w_en       = ~r_skid_vld;
    assign o_s_tready = w_en;

    // Stage A: inputs, with the conjugate applied for subtraction.
    logic signed [15:0] w_ac, w_as;
    logic signed [16:0] w_bc, w_bs;
    logic               r_a_vld;
    logic signed [15:0] r_ac, r_as;
    logic signed [16:0] r_bc, r_bs;

    always_comb begin
        w_ac = i_s_tdata[15:0];
        w_as = i_s_tdata[31:16];
        w_bc = 17'($signed(i_s_tdata[47:32]));
        w_bs = 17'($signed(i_s_tdata[63:48]));
        if (i_s_tuser) begin
            if (w_bc == '0 && w_bs == '0) begin
                w_bc = 17'sd1;
            end
            w_bs = -w_bs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ac <= w_ac;
            r_as <= w_as;
            r_bc <= w_bc;
            r_bs <= w_bs;
        end
    end

    // Stage B: the four partial products.
    logic               r_b_vld;
    logic signed [32:0] r_pcc, r_pss, r_pcs, r_psc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pcc <= r_ac * r_bc;
            r_pss <= r_as * r_bs;
            r_pcs <= r_ac * r_bs;
            r_psc <= r_as * r_bc;
        end
    end

    // Stage C: real and imaginary parts of the product.
    logic               r_c_vld;
    logic signed [32:0] r_x, r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (w_en) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x <= r_pcc - r_pss;
            r_y <= r_pcs + r_psc;
        end
    end

    // Stage D: magnitudes, signs and the zero product flag.
    logic          r_d_vld;
    logic [MW-1:0] r_d_ux, r_d_uy;
    logic          r_d_nx, r_d_ny, r_d_zero;
    logic [32:0]   w_ax, w_ay;

    assign w_ax = r_x[32] ? 33'(-r_x) : 33'(r_x);
    assign w_ay = r_y[32] ? 33'(-r_y) : 33'(r_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (w_en) begin
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_ux   <= w_ax[MW-1:0];
            r_d_uy   <= w_ay[MW-1:0];
            r_d_nx   <= r_x[32];
            r_d_ny   <= r_y[32];
            r_d_zero <= (r_x == '0) && (r_y == '0);
        end
    end

    // Stage E: larger magnitude and leading zero counts of its two halves.
    logic          r_e_vld;
    logic [MW-1:0] r_e_ux, r_e_uy;
    logic          r_e_nx, r_e_ny, r_e_zero;
    logic          r_e_top, r_e_hi_z;
    logic [4:0]    r_e_lz_hi, r_e_lz_lo;
    logic [MW-1:0] w_big;

    assign w_big = (r_d_ux > r_d_uy) ? r_d_ux : r_d_uy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (w_en) begin
            r_e_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_ux    <= r_d_ux;
            r_e_uy    <= r_d_uy;
            r_e_nx    <= r_d_nx;
            r_e_ny    <= r_d_ny;
            r_e_zero  <= r_d_zero;
            r_e_top   <= w_big[31];
            r_e_hi_z  <= (w_big[30:15] == '0);
            r_e_lz_hi <= lz16(w_big[30:15]);
            r_e_lz_lo <= lz16({w_big[14:0], 1'b1});
        end
    end

    // Stage F: shift both parts so the larger lies in [2^30, 2^31].
    logic          r_f_vld;
    logic [MW-1:0] r_f_sx, r_f_sy;
    logic          r_f_nx, r_f_ny, r_f_zero;
    logic [4:0]    w_shift;

    always_comb begin
        if (r_e_top) begin
            w_shift = '0;
        end else if (r_e_hi_z) begin
            w_shift = 5'd16 + r_e_lz_lo;
        end else begin
            w_shift = r_e_lz_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (w_en) begin
            r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_sx   <= r_e_ux << w_shift;
            r_f_sy   <= r_e_uy << w_shift;
            r_f_nx   <= r_e_nx;
            r_f_ny   <= r_e_ny;
            r_f_zero <= r_e_zero;
        end
    end

    // Stage G: squares of both parts.
    logic                      r_g_vld;
    logic [rcn_pkg::RAD_W-1:0] r_g_qx, r_g_qy;
    logic [MW-1:0]             r_g_sx, r_g_sy;
    logic                      r_g_nx, r_g_ny, r_g_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
        end else if (w_en) begin
            r_g_vld <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g_qx   <= rcn_pkg::RAD_W'(r_f_sx) * rcn_pkg::RAD_W'(r_f_sx);
            r_g_qy   <= rcn_pkg::RAD_W'(r_f_sy) * rcn_pkg::RAD_W'(r_f_sy);
            r_g_sx   <= r_f_sx;
            r_g_sy   <= r_f_sy;
            r_g_nx   <= r_f_nx;
            r_g_ny   <= r_f_ny;
            r_g_zero <= r_f_zero;
        end
    end

    // Stage H: sum of squares.
    localparam int SQ_SIDE_W = 2 * MW + 3;
    logic                      r_h_vld;
    logic [rcn_pkg::RAD_W-1:0] r_h_sum;
    logic [SQ_SIDE_W-1:0]      r_h_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
        end else if (w_en) begin
            r_h_vld <= r_g_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_h_sum  <= r_g_qx + r_g_qy;
            r_h_side <= {r_g_zero, r_g_nx, r_g_ny, r_g_sx, r_g_sy};
        end
    end

    // Norm of the shifted product.
    logic                 w_sq_vld;
    logic [MW-1:0]        w_norm;
    logic [SQ_SIDE_W-1:0] w_sq_side;

    rcn_sqrt_pipe #(
        .SIDE_W (SQ_SIDE_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_h_vld),
        .i_rad   (r_h_sum),
        .i_side  (r_h_side),
        .o_vld   (w_sq_vld),
        .o_root  (w_norm),
        .o_side  (w_sq_side)
    );

    // Both parts divided by the norm in parallel lanes.
    logic               w_dvc_vld, w_dvs_vld;
    logic [FRAC_BITS:0] w_qc, w_qs;
    logic [1:0]         w_dvc_side;
    logic               w_dvs_side;

    rcn_div_pipe #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (2)
    ) u_div_cos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_sq_vld),
        .i_mag   (w_sq_side[2*MW-1:MW]),
        .i_norm  (w_norm),
        .i_side  (w_sq_side[2*MW+2:2*MW+1]),
        .o_vld   (w_dvc_vld),
        .o_quo   (w_qc),
        .o_side  (w_dvc_side)
    );

    rcn_div_pipe #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (1)
    ) u_div_sin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_sq_vld),
        .i_mag   (w_sq_side[MW-1:0]),
        .i_norm  (w_norm),
        .i_side  (w_sq_side[2*MW]),
        .o_vld   (w_dvs_vld),
        .o_quo   (w_qs),
        .o_side  (w_dvs_side)
    );

    // Saturate a rounded quotient and restore its sign.
    function automatic logic [15:0] sat_part(input logic [31:0] q, input logic neg);
        logic [31:0] m;
        if (neg) begin
            m = (q > LIM_N) ? LIM_N : q;
            m = -m;
        end else begin
            m = (q > LIM_P) ? LIM_P : q;
        end
        return m[15:0];
    endfunction

    // Final stage: saturation, or the identity for a zero product.
    rcn_pkg::t_res n_fin;
    rcn_pkg::t_res r_fin;
    logic          r_fin_vld;

    always_comb begin
        n_fin.deg = w_dvc_side[1];
        if (w_dvc_side[1]) begin
            n_fin.cos = LIM_P[15:0];
            n_fin.sin = '0;
        end else begin
            n_fin.cos = sat_part(32'(w_qc), w_dvc_side[0]);
            n_fin.sin = sat_part(32'(w_qs), w_dvs_side);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_vld <= 1'b0;
        end else if (w_en) begin
            r_fin_vld <= w_dvc_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fin <= n_fin;
        end
    end

    // Output register with a skid register behind it.
    logic          w_push, w_pop;
    logic          r_out_vld;
    rcn_pkg::t_res r_out, r_skid;

    assign w_push = w_en & r_fin_vld;
    assign w_pop  = ~r_out_vld | i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (w_pop) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= w_push;
            end
        end else if (w_push) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_out <= r_skid_vld ? r_skid : r_fin;
        end else if (w_push) begin
            r_skid <= r_fin;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {r_out.sin, r_out.cos};
    assign o_m_tuser  = r_out.deg;

    // Checks on the output buffering and the divider lanes.
    `RCN_ASSERT_IMP(a_skid_behind_out, r_skid_vld, r_out_vld)
    `RCN_ASSERT_NXT(a_stall_fills_skid, r_out_vld && !i_m_tready && w_push, r_skid_vld)
    `RCN_ASSERT_IMP(a_lanes_aligned, 1'b1, w_dvc_vld == w_dvs_vld)
    `RCN_ASSERT_IMP(a_degenerate_zero_sin, r_out_vld && r_out.deg, r_out.sin == '0)

endmodule
